// ----- hw/rtl/tgr_pkg.sv -----
// Shared types, codes and constants for the touch gesture recognizer.
package tgr_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PctW   = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned LimW   = CoordW + PctW;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned ScaleW = 14;
  localparam int unsigned ProdW  = SumW + ScaleW;
  localparam int unsigned LimSqW = 2 * LimW;

  localparam logic [ScaleW-1:0] MoveScale   = 14'd10000;
  localparam logic [CoordW-1:0] ShortPixels = 12'd40;

  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_MOVE    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_ABORT   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [2:0] G_NONE  = 3'd0;
  localparam logic [2:0] G_LONG  = 3'd1;
  localparam logic [2:0] G_RIGHT = 3'd2;
  localparam logic [2:0] G_LEFT  = 3'd3;
  localparam logic [2:0] G_DOWN  = 3'd4;
  localparam logic [2:0] G_UP    = 3'd5;

  localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MOVE_PCT    = 2'd2;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd3;

  localparam logic [CoordW-1:0] AreaWidthReset  = 12'd320;
  localparam logic [CoordW-1:0] AreaHeightReset = 12'd320;
  localparam logic [PctW-1:0]   MovePctReset    = 7'd0;
  localparam logic [TickW-1:0]  LongTicksReset  = 16'd1000;

  typedef struct packed {
    logic [CoordW-1:0] area_width;
    logic [CoordW-1:0] area_height;
    logic [PctW-1:0]   move_cancel_pct;
    logic [TickW-1:0]  long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic calc_diff;
    logic calc_mul1;
    logic calc_mul2;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_is_move;
  } ctl_sts_t;

endpackage

// ----- hw/rtl/tgr_cfg_regs.sv -----
// Configuration register file behind the APB-style port.
module tgr_cfg_regs
  import tgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_width       <= AreaWidthReset;
      cfg_r.area_height      <= AreaHeightReset;
      cfg_r.move_cancel_pct  <= MovePctReset;
      cfg_r.long_press_ticks <= LongTicksReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_AREA_WIDTH:  cfg_r.area_width       <= pwdata[CoordW-1:0];
        REG_AREA_HEIGHT: cfg_r.area_height      <= pwdata[CoordW-1:0];
        REG_MOVE_PCT:    cfg_r.move_cancel_pct  <= pwdata[PctW-1:0];
        REG_LONG_TICKS:  cfg_r.long_press_ticks <= pwdata[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AREA_WIDTH:  prdata = {{(32-CoordW){1'b0}}, cfg_r.area_width};
      REG_AREA_HEIGHT: prdata = {{(32-CoordW){1'b0}}, cfg_r.area_height};
      REG_MOVE_PCT:    prdata = {{(32-PctW){1'b0}}, cfg_r.move_cancel_pct};
      REG_LONG_TICKS:  prdata = {{(32-TickW){1'b0}}, cfg_r.long_press_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/tgr_ctrl.sv -----
// Controller state machine that sequences one touch event and owns the output handshake.
module tgr_ctrl
  import tgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_EXEC = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = sts.op_is_move ? S_MUL1 : S_EXEC;
      end
      S_MUL1: begin
        cmd.calc_mul1 = 1'b1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd.calc_mul2 = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/tgr_datapath.sv -----
// Datapath with the touch state, distance arithmetic and result register.
module tgr_datapath
  import tgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  input  logic [2:0]        opcode,
  input  logic [CoordW-1:0] pos_x,
  input  logic [CoordW-1:0] pos_y,
  input  logic              child_took_release,
  output logic [2:0]        gesture_code,
  output logic              stop_flag,
  output logic              abort_request,
  output logic              pressed_now
);

  logic [2:0]        op_r;
  logic [CoordW-1:0] x_r, y_r;
  logic              child_r;

  logic [CoordW-1:0] dx_r, dy_r;
  logic [SqW-1:0]    sqx_r, sqy_r;
  logic [LimW-1:0]   lim_r;
  logic [ProdW-1:0]  prod_r;
  logic [LimSqW-1:0] limsq_r;

  logic              pressed_r, pressed_nxt;
  logic              mark_r, mark_nxt;
  logic [CoordW-1:0] press_x_r, press_x_nxt;
  logic [CoordW-1:0] press_y_r, press_y_nxt;
  logic              armed_r, armed_nxt;
  logic [TickW-1:0]  cd_r, cd_nxt;

  logic [2:0] code_r, code_nxt;
  logic       stop_r, stop_nxt;
  logic       abort_r, abort_nxt;
  logic       pnow_r;

  logic [CoordW-1:0] side;
  logic              short_x, short_y, is_short, same_pt;
  logic [CoordW+2:0] dx5, dy5;

  assign sts.op_is_move = (op_r == OP_MOVE);
  assign side = (cfg.area_width < cfg.area_height) ? cfg.area_width : cfg.area_height;

  assign dx5     = {3'b000, dx_r} + {1'b0, dx_r, 2'b00};
  assign dy5     = {3'b000, dy_r} + {1'b0, dy_r, 2'b00};
  assign short_x = (dx_r < ShortPixels) && (dx5 < {3'b000, cfg.area_width});
  assign short_y = (dy_r < ShortPixels) && (dy5 < {3'b000, cfg.area_height});
  assign same_pt = (x_r == press_x_r) && (y_r == press_y_r);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= opcode;
      x_r     <= pos_x;
      y_r     <= pos_y;
      child_r <= child_took_release;
    end
    if (cmd.calc_diff) begin
      dx_r <= (press_x_r > x_r) ? (press_x_r - x_r) : (x_r - press_x_r);
      dy_r <= (press_y_r > y_r) ? (press_y_r - y_r) : (y_r - press_y_r);
    end
    if (cmd.calc_mul1) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
      lim_r <= side * cfg.move_cancel_pct;
    end
    if (cmd.calc_mul2) begin
      prod_r  <= ({1'b0, sqx_r} + {1'b0, sqy_r}) * MoveScale;
      limsq_r <= lim_r * lim_r;
    end
  end

  always_comb begin
    pressed_nxt = pressed_r;
    mark_nxt    = mark_r;
    press_x_nxt = press_x_r;
    press_y_nxt = press_y_r;
    armed_nxt   = armed_r;
    cd_nxt      = cd_r;
    code_nxt    = G_NONE;
    stop_nxt    = 1'b0;
    abort_nxt   = 1'b0;
    is_short    = 1'b0;
    case (op_r)
      OP_PRESS: begin
        pressed_nxt = 1'b1;
        press_x_nxt = x_r;
        press_y_nxt = y_r;
        armed_nxt   = 1'b1;
        cd_nxt      = cfg.long_press_ticks;
      end
      OP_MOVE: begin
        if (pressed_r && (prod_r > {1'b0, limsq_r})) begin
          armed_nxt = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (child_r) begin
          mark_nxt = 1'b0;
        end else if (pressed_r) begin
          if (!same_pt) begin
            if (dx_r > dy_r) begin
              if (short_x) begin
                is_short = 1'b1;
              end else begin
                code_nxt = (x_r > press_x_r) ? G_RIGHT : G_LEFT;
              end
            end else begin
              if (short_y) begin
                is_short = 1'b1;
              end else begin
                code_nxt = (y_r > press_y_r) ? G_DOWN : G_UP;
              end
            end
          end
          if (!is_short && mark_r) begin
            mark_nxt = 1'b0;
            stop_nxt = 1'b1;
          end
        end
        pressed_nxt = 1'b0;
        armed_nxt   = 1'b0;
      end
      OP_ABORT: begin
        if (pressed_r) begin
          pressed_nxt = 1'b0;
          armed_nxt   = 1'b0;
        end
      end
      OP_TICK: begin
        if (armed_r) begin
          if (cd_r <= 16'd1) begin
            cd_nxt    = '0;
            armed_nxt = 1'b0;
            if (pressed_r) begin
              code_nxt    = G_LONG;
              pressed_nxt = 1'b0;
              mark_nxt    = 1'b1;
              abort_nxt   = 1'b1;
            end
          end else begin
            cd_nxt = cd_r - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      mark_r    <= 1'b0;
      press_x_r <= '0;
      press_y_r <= '0;
      armed_r   <= 1'b0;
      cd_r      <= '0;
    end else if (cmd.commit) begin
      pressed_r <= pressed_nxt;
      mark_r    <= mark_nxt;
      press_x_r <= press_x_nxt;
      press_y_r <= press_y_nxt;
      armed_r   <= armed_nxt;
      cd_r      <= cd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      code_r  <= code_nxt;
      stop_r  <= stop_nxt;
      abort_r <= abort_nxt;
      pnow_r  <= pressed_nxt;
    end
  end

  assign gesture_code  = code_r;
  assign stop_flag     = stop_r;
  assign abort_request = abort_r;
  assign pressed_now   = pnow_r;

endmodule

// ----- hw/rtl/touch_gesture_recognizer.sv -----
// Touch gesture recognizer: swipe and long-press detection for one touch area.
// A move event runs DIFF, MUL1 and MUL2 (the two-multiplier distance sequence) before
// EXEC commits its result; other events go from DIFF straight to EXEC. The controller
// accepts one event at a time, none until the last is committed. A waiting result holds the next commit.
// Reset is synchronous, active low: touch state cleared, registers back to defaults.
module touch_gesture_recognizer
  import tgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pos_x[11:0], pos_y[23:12]
  input  logic [3:0]  in_tuser,   // opcode[2:0], child_took_release[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // gesture_code[2:0], stop_flag[3], abort_request[4],
                                  // pressed_now[5], zero[7:6]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg;
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [2:0] gesture_code;
  logic       stop_flag, abort_request, pressed_now;

  assign cfg_pready = 1'b1;

  tgr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  tgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tgr_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .opcode             (in_tuser[2:0]),
    .pos_x              (in_tdata[11:0]),
    .pos_y              (in_tdata[23:12]),
    .child_took_release (in_tuser[3]),
    .gesture_code       (gesture_code),
    .stop_flag          (stop_flag),
    .abort_request      (abort_request),
    .pressed_now        (pressed_now)
  );

  assign out_tdata = {2'b00, pressed_now, abort_request, stop_flag, gesture_code};

endmodule
